FILE: design/smcc_pkg.sv
package smcc_pkg;

   // Command codes of the request item
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_LOAD_COST    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_CONTRIB = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN          = 2'd2;

   // Register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;

   // Field widths
   localparam int COUNT_W  = 5;
   localparam int INDEX_W  = 4;
   localparam int VALUE_W  = 17;
   localparam int SUM_W    = 21;
   localparam int SUBSET_W = 16;

   localparam logic [COUNT_W-1:0] ITEM_COUNT_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] DIM_COUNT_RESET  = 5'd16;
   localparam logic [VALUE_W-1:0] THRESHOLD_RESET  = 17'd0;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] item_index;
      logic [INDEX_W-1:0] dim_index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] min_cost;
      logic             found;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_cost;
      logic load_contrib;
      logic run_init;
      logic issue;
      logic decide;
      logic emit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic dims_zero;
      logic dim_last;
      logic subset_last;
   } dp_status_type;

endpackage

FILE: design/smcc_ctrl.sv
module smcc_ctrl
   import smcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_cmd,
   input  dp_status_type    status,
   output logic             busy,
   output ctrl_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PASS   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_LOAD_COST: begin
                     cmd.load_cost = 1'b1;
                  end
                  CMD_LOAD_CONTRIB: begin
                     cmd.load_contrib = 1'b1;
                  end
                  CMD_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = ST_PASS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PASS: begin
            // one dimension per cycle through the sum memory
            if (status.dims_zero) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.issue = 1'b1;
               if (status.dim_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.subset_last) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PASS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_run_enters_pass: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_RUN) |=> state_ff == ST_PASS)
      else $error("run item did not start a dimension pass");

   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !busy)
      else $error("still busy after the result was sent");

endmodule

FILE: design/smcc_datapath.sv
module smcc_datapath
   import smcc_pkg::*;
#(
   parameter int MAX_ITEMS = 16,
   parameter int MAX_DIMS  = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   localparam int ITEM_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DCNT_W = DIM_W + 1;
   localparam int DEPTH  = MAX_ITEMS * MAX_DIMS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_DIMS);

   // Configuration
   logic [COUNT_W-1:0] item_count_ff;
   logic [COUNT_W-1:0] dim_count_ff;
   logic [VALUE_W-1:0] threshold_ff;

   // Stores
   logic [VALUE_W-1:0] cost_mem    [MAX_ITEMS];
   logic [VALUE_W-1:0] contrib_mem [DEPTH];
   logic [SUM_W-1:0]   sum_mem     [MAX_DIMS];
   logic [VALUE_W-1:0] contrib_q;
   logic [SUM_W-1:0]   sum_q;

   // Search state
   logic [DCNT_W-1:0]    dims_ff;
   logic [SUBSET_W-1:0]  last_ff;
   logic [SUBSET_W-1:0]  k_ff;
   logic [MAX_ITEMS-1:0] gray_ff;
   logic [SUM_W-1:0]     cost_ff;
   logic [SUM_W-1:0]     best_ff;
   logic                 found_ff;
   logic                 ok_ff;
   logic                 first_ff;
   logic                 dir_ff;
   logic [ITEM_W-1:0]    item_ff;
   logic [DCNT_W-1:0]    d_ff;
   logic                 rd_valid_ff;
   logic [DIM_W-1:0]     rd_dim_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 load_item_ok;
   logic                 load_dim_ok;
   logic [ADDR_W-1:0]    load_addr;
   logic [ADDR_W-1:0]    read_addr;
   logic [SUM_W-1:0]     new_sum;
   logic                 pass_ok;
   logic                 better;
   logic [SUM_W-1:0]     best_next;
   logic                 found_next;
   logic [SUBSET_W-1:0]  k_next;
   logic [ITEM_W-1:0]    flip;
   logic                 flip_bit;
   logic [MAX_ITEMS-1:0] gray_next;
   logic [SUM_W-1:0]     cost_next;
   logic [DCNT_W-1:0]    dims_sat;
   logic [COUNT_W-1:0]   items_sat;
   logic [SUBSET_W:0]    span;

   function automatic logic [ITEM_W-1:0] lowest_set(input logic [MAX_ITEMS-1:0] v);
      logic [ITEM_W-1:0] idx;
      idx = '0;
      for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = ITEM_W'(i);
         end
      end
      return idx;
   endfunction

   assign load_item_ok = (int'(req_data.item_index) < MAX_ITEMS);
   assign load_dim_ok  = (int'(req_data.dim_index) < MAX_DIMS);
   assign load_addr    = ADDR_W'(req_data.item_index) * STRIDE + ADDR_W'(req_data.dim_index);
   assign read_addr    = ADDR_W'(item_ff) * STRIDE + ADDR_W'(d_ff[DIM_W-1:0]);

   // Second stage of the dimension pass: update one sum and test it
   always_comb begin
      if (first_ff) begin
         new_sum = '0;
      end else if (dir_ff) begin
         new_sum = sum_q + SUM_W'(contrib_q);
      end else begin
         new_sum = sum_q - SUM_W'(contrib_q);
      end
   end
   assign pass_ok = (new_sum >= SUM_W'(threshold_ff));

   assign better     = ok_ff && (!found_ff || (cost_ff < best_ff));
   assign best_next  = better ? cost_ff : best_ff;
   assign found_next = found_ff || better;

   // Gray-code step: flip the item at the lowest set bit of the next count
   assign k_next   = k_ff + SUBSET_W'(1);
   assign flip     = lowest_set(k_next[MAX_ITEMS-1:0]);
   assign flip_bit = ~gray_ff[flip];
   always_comb begin
      gray_next       = gray_ff;
      gray_next[flip] = flip_bit;
   end
   assign cost_next = flip_bit ? cost_ff + SUM_W'(cost_mem[flip])
                               : cost_ff - SUM_W'(cost_mem[flip]);

   assign dims_sat  = (int'(dim_count_ff) > MAX_DIMS) ? DCNT_W'(MAX_DIMS)
                                                      : DCNT_W'(dim_count_ff);
   assign items_sat = (int'(item_count_ff) > MAX_ITEMS) ? COUNT_W'(MAX_ITEMS)
                                                        : item_count_ff;
   assign span      = ((SUBSET_W + 1)'(1) << items_sat) - (SUBSET_W + 1)'(1);

   assign status.dims_zero   = (dims_ff == '0);
   assign status.dim_last    = (d_ff == dims_ff - DCNT_W'(1));
   assign status.subset_last = (k_ff == last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= ITEM_COUNT_RESET;
         dim_count_ff  <= DIM_COUNT_RESET;
         threshold_ff  <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ITEM_COUNT: item_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DIM_COUNT:  dim_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[VALUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cost && load_item_ok) begin
         cost_mem[req_data.item_index[ITEM_W-1:0]] <= req_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_contrib && load_item_ok && load_dim_ok) begin
         contrib_mem[load_addr] <= req_data.value;
      end
      contrib_q <= contrib_mem[read_addr];
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         sum_mem[rd_dim_ff] <= new_sum;
      end
      sum_q <= sum_mem[d_ff[DIM_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.issue;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rd_dim_ff <= d_ff[DIM_W-1:0];
      if (cmd.run_init) begin
         dims_ff  <= dims_sat;
         last_ff  <= span[SUBSET_W-1:0];
         k_ff     <= '0;
         gray_ff  <= '0;
         cost_ff  <= '0;
         best_ff  <= '1;
         found_ff <= 1'b0;
         ok_ff    <= 1'b1;
         first_ff <= 1'b1;
         dir_ff   <= 1'b1;
         item_ff  <= '0;
         d_ff     <= '0;
      end else if (cmd.decide) begin
         best_ff  <= best_next;
         found_ff <= found_next;
         ok_ff    <= 1'b1;
         d_ff     <= '0;
         if (!cmd.emit) begin
            k_ff     <= k_next;
            gray_ff  <= gray_next;
            cost_ff  <= cost_next;
            first_ff <= 1'b0;
            dir_ff   <= flip_bit;
            item_ff  <= flip;
         end
      end else begin
         if (cmd.issue) begin
            d_ff <= d_ff + DCNT_W'(1);
         end
         if (rd_valid_ff) begin
            ok_ff <= ok_ff && pass_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.found    <= found_next;
         rsp_ff.min_cost <= found_next ? best_next : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_decide_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> !rd_valid_ff)
      else $error("subset decided while a dimension update was in flight");

   a_no_cover_zero_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.min_cost == '0)
      else $error("nonzero cost reported without a cover");

endmodule

FILE: design/subset_min_cost_cover_search.sv
// Minimum-cost cover search. Load each item's cost (cmd 0) and its contribution per
// dimension (cmd 1); a load leaves busy low, so the block stays ready. A run
// item (cmd 2) walks all 2^n subsets of the first n = item_count items in Gray-code
// order, flipping one item per subset, and keeps the least cost among subsets whose
// sums reach threshold in every one of the first dim_count dimensions. The run is
// busy while it walks, paced by the sum memory that updates one dimension per
// cycle, with a drain state and a decision state per subset; the result appears
// as busy falls. The result is a one-cycle strobe on rsp_valid that the receiver
// cannot hold off, so it must be taken when it appears. Loads and runs are
// refused while busy is high.
module subset_min_cost_cover_search
   import smcc_pkg::*;
#(
   parameter int MAX_ITEMS = 16,
   parameter int MAX_DIMS  = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   smcc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   smcc_datapath #(
      .MAX_ITEMS (MAX_ITEMS),
      .MAX_DIMS  (MAX_DIMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/cover_search_checker.sv
module cover_search_checker
   import smcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_SLOTS = 16;
   localparam int DIM_SLOTS  = 16;

   logic [VALUE_W-1:0] cost_mem [ITEM_SLOTS];
   logic [VALUE_W-1:0] contrib_mem [ITEM_SLOTS][DIM_SLOTS];
   logic [COUNT_W-1:0] item_count_reg = ITEM_COUNT_RESET;
   logic [COUNT_W-1:0] dim_count_reg = DIM_COUNT_RESET;
   logic [VALUE_W-1:0] threshold_reg = THRESHOLD_RESET;
   rsp_type            cover_cost_q[$];
   int                 mismatches = 0;

   initial begin
      for (int i = 0; i < ITEM_SLOTS; i++) begin
         cost_mem[i] = '0;
         for (int d = 0; d < DIM_SLOTS; d++) contrib_mem[i][d] = '0;
      end
   end

   // Try every subset of the active items; keep the cheapest one that covers all dims.
   function automatic rsp_type least_cover_cost();
      int               n_items;
      int               n_dims;
      logic [SUM_W-1:0] dim_sum [DIM_SLOTS];
      logic [SUM_W-1:0] total;
      logic [SUM_W-1:0] best;
      logic             covered;
      logic             hit;
      rsp_type          res;
      n_items = (item_count_reg > ITEM_SLOTS) ? ITEM_SLOTS : int'(item_count_reg);
      n_dims = (dim_count_reg > DIM_SLOTS) ? DIM_SLOTS : int'(dim_count_reg);
      hit = 1'b0;
      best = '1;
      for (int s = 0; s < (1 << n_items); s++) begin
         total = '0;
         for (int d = 0; d < DIM_SLOTS; d++) dim_sum[d] = '0;
         for (int i = 0; i < n_items; i++) begin
            if (s[i]) begin
               total += cost_mem[i];
               for (int d = 0; d < n_dims; d++) dim_sum[d] += contrib_mem[i][d];
            end
         end
         covered = 1'b1;
         for (int d = 0; d < n_dims; d++) begin
            if (dim_sum[d] < threshold_reg) covered = 1'b0;
         end
         if (covered && (!hit || total < best)) begin
            best = total;
            hit = 1'b1;
         end
      end
      res.min_cost = hit ? best : '0;
      res.found = hit;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         item_count_reg = ITEM_COUNT_RESET;
         dim_count_reg = DIM_COUNT_RESET;
         threshold_reg = THRESHOLD_RESET;
         cover_cost_q.delete();
      end else begin
         if (rsp_valid) begin
            if (cover_cost_q.size() == 0) begin
               $error("unexpected result: min_cost=%0d found=%0d",
                      rsp_data.min_cost, rsp_data.found);
               mismatches++;
            end else begin
               want = cover_cost_q.pop_front();
               if (rsp_data.min_cost !== want.min_cost) begin
                  $error("min_cost: expected %0d, actual %0d", want.min_cost, rsp_data.min_cost);
                  mismatches++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ITEM_COUNT: item_count_reg = csr_wdata[COUNT_W-1:0];
               CSR_DIM_COUNT:  dim_count_reg = csr_wdata[COUNT_W-1:0];
               CSR_THRESHOLD:  threshold_reg = csr_wdata[VALUE_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_data.cmd)
               CMD_LOAD_COST:    cost_mem[req_data.item_index] = req_data.value;
               CMD_LOAD_CONTRIB:
                  contrib_mem[req_data.item_index][req_data.dim_index] = req_data.value;
               CMD_RUN:          cover_cost_q.push_back(least_cover_cost());
               default: ;
            endcase
         end
      end
      pending_count <= cover_cost_q.size();
      fail_count <= mismatches;
   end

endmodule

FILE: test/subset_min_cost_cover_search_tb.sv
module subset_min_cost_cover_search_tb;
   import smcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;
   localparam logic [VALUE_W-1:0]   VALUE_MAX  = '1;
   localparam int ITEM_SLOTS   = 16;
   localparam int DIM_SLOTS    = 16;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 10000000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   int                    fail_count;
   int                    pending_count;

   int item_lim = ITEM_SLOTS;
   int dim_lim = DIM_SLOTS;
   int sent_count = 0;
   int cycle_count = 0;
   bit cost_set [ITEM_SLOTS];
   bit contrib_set [ITEM_SLOTS][DIM_SLOTS];

   subset_min_cost_cover_search dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   cover_search_checker cover_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input req_type item);
      if ((sent_count < 400 || sent_count >= 700) && $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (item.cmd == CMD_LOAD_COST) cost_set[item.item_index] = 1'b1;
      if (item.cmd == CMD_LOAD_CONTRIB) contrib_set[item.item_index][item.dim_index] = 1'b1;
      sent_count++;
   endtask

   task automatic issue(input logic [CMD_W-1:0] cmd, input int item, input int dim, input int value);
      req_type r;
      r.cmd = cmd;
      r.item_index = item[INDEX_W-1:0];
      r.dim_index = dim[INDEX_W-1:0];
      r.value = value[VALUE_W-1:0];
      send_item(r);
   endtask

   task automatic issue_run();
      issue(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, VALUE_MAX));
   endtask

   task automatic issue_noise(input int value_max);
      int pick;
      pick = $urandom_range(0, 9);
      issue(pick == 0 ? CMD_UNUSED : (pick < 5 ? CMD_LOAD_COST : CMD_LOAD_CONTRIB),
            $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, value_max));
   endtask

   // Drop start, then wait until the last run has reported and the block is quiet.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Count registers keep only their low bits; fill the rest with junk now and then.
   function automatic logic [CSR_DATA_W-1:0] padded(input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(0, 1) ? '0 : CSR_DATA_W'($urandom_range(0, 4095)) << COUNT_W;
      return junk | count;
   endfunction

   task automatic set_config(input int items, input int dims, input logic [VALUE_W-1:0] thr);
      csr_write(CSR_ITEM_COUNT, padded(COUNT_W'(items)));
      csr_write(CSR_DIM_COUNT, padded(COUNT_W'(dims)));
      csr_write(CSR_THRESHOLD, thr);
      csr_we <= 1'b0;
      item_lim = (items > ITEM_SLOTS) ? ITEM_SLOTS : items;
      dim_lim = (dims > DIM_SLOTS) ? DIM_SLOTS : dims;
   endtask

   // One search: configure, make sure every entry the search will read is loaded, then run it.
   task automatic search_pass(input int items, input int dims, input int value_max);
      logic [VALUE_W-1:0] thr;
      int                 thr_top;
      thr_top = (2 * value_max > VALUE_MAX) ? VALUE_MAX : 2 * value_max;
      case ($urandom_range(0, 19))
         0, 1, 2: thr = '0;
         3, 4:    thr = VALUE_MAX;
         default: thr = VALUE_W'($urandom_range(0, thr_top));
      endcase
      drain();
      set_config(items, dims, thr);
      repeat ($urandom_range(0, 6)) issue_noise(value_max);
      for (int i = 0; i < item_lim; i++) begin
         if (!cost_set[i] || $urandom_range(0, 3) == 0)
            issue(CMD_LOAD_COST, i, $urandom_range(0, 15), $urandom_range(0, value_max));
         for (int d = 0; d < dim_lim; d++) begin
            if (!contrib_set[i][d] || $urandom_range(0, 3) == 0)
               issue(CMD_LOAD_CONTRIB, i, d, $urandom_range(0, value_max));
         end
      end
      issue_run();
      // Offer a noise item right behind the run so it waits out the busy period.
      if ($urandom_range(0, 1)) issue_noise(value_max);
   endtask

   initial begin
      int items;
      int dims;
      int value_max;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      csr_write(CSR_SPARE, '1);
      set_config(2, 2, '0);
      issue(CMD_LOAD_COST, 0, 0, VALUE_MAX);
      issue(CMD_LOAD_COST, 1, 15, 0);
      issue(CMD_LOAD_CONTRIB, 0, 0, VALUE_MAX);
      issue(CMD_LOAD_CONTRIB, 0, 1, 0);
      issue(CMD_LOAD_CONTRIB, 1, 0, 0);
      issue(CMD_LOAD_CONTRIB, 1, 1, VALUE_MAX);
      issue(CMD_UNUSED, 15, 15, VALUE_MAX);
      issue(CMD_LOAD_COST, 15, 15, VALUE_MAX);
      issue(CMD_LOAD_CONTRIB, 15, 15, 0);
      issue(CMD_LOAD_CONTRIB, 15, 0, VALUE_MAX);
      issue_run();
      // Full threshold: both items are needed to cover both dims.
      drain();
      set_config(2, 2, VALUE_MAX);
      issue_run();
      // No dims to cover: the empty subset wins.
      drain();
      set_config(2, 0, VALUE_MAX);
      issue_run();
      // No items: only the empty subset, which misses a threshold of one.
      drain();
      set_config(0, 2, VALUE_W'(1));
      issue_run();

      while (sent_count < RANDOM_ITEMS) begin
         items = $urandom_range(0, 8);
         if (items <= 3 && $urandom_range(0, 19) == 0) dims = $urandom_range(17, 31);
         else if (items <= 5) dims = $urandom_range(0, 16);
         else dims = $urandom_range(0, 6);
         case ($urandom_range(0, 3))
            0:       value_max = 15;
            1:       value_max = 1000;
            default: value_max = VALUE_MAX;
         endcase
         search_pass(items, dims, value_max);
      end

      // Largest searches: an oversized item count, then exactly the maximum.
      search_pass(31, 1, VALUE_MAX);
      search_pass(16, 0, VALUE_MAX);
      drain();
      repeat (20) @(posedge clock);

      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
design/smcc_pkg.sv
design/smcc_ctrl.sv
design/smcc_datapath.sv
design/subset_min_cost_cover_search.sv
test/cover_search_checker.sv
test/subset_min_cost_cover_search_tb.sv
